>>> src/gcode_line_parser_unit_defines.svh
// ---------------------------------------------------------------------------
// gcode_line_parser_unit_defines.svh
// Assertion macros shared by the line parser RTL.
// ---------------------------------------------------------------------------
`ifndef GCODE_LINE_PARSER_UNIT_DEFINES_SVH
`define GCODE_LINE_PARSER_UNIT_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define GLP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define GLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> src/glp_pkg.sv
// ---------------------------------------------------------------------------
// glp_pkg
// Character codes, result codes and small tables for the line parser.
// ---------------------------------------------------------------------------
package glp_pkg;

  // Input item kinds.
  localparam logic KIND_CHAR = 1'b0;
  localparam logic KIND_EOL  = 1'b1;

  // Command letters as reported in the result.
  localparam logic [2:0] LET_NONE  = 3'd0;
  localparam logic [2:0] LET_G     = 3'd1;
  localparam logic [2:0] LET_D     = 3'd2;
  localparam logic [2:0] LET_P     = 3'd3;
  localparam logic [2:0] LET_H     = 3'd4;
  localparam logic [2:0] LET_M     = 3'd5;
  localparam logic [2:0] LET_BANG  = 3'd6;
  localparam logic [2:0] LET_TILDE = 3'd7;

  // Error codes.
  localparam logic [3:0] ERR_NONE       = 4'd0;
  localparam logic [3:0] ERR_EMPTY      = 4'd1;
  localparam logic [3:0] ERR_BAD_TYPE   = 4'd2;
  localparam logic [3:0] ERR_NO_CODE    = 4'd3;
  localparam logic [3:0] ERR_BAD_COORD  = 4'd4;
  localparam logic [3:0] ERR_MOVE_NO_XY = 4'd5;
  localparam logic [3:0] ERR_DOT_NO_XY  = 4'd6;
  localparam logic [3:0] ERR_PEN_CODE   = 4'd7;
  localparam logic [3:0] ERR_BAD_M      = 4'd8;

  // ASCII characters the parser recognizes (after folding to upper case).
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_D     = 8'h44;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_M     = 8'h4D;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_TILDE = 8'h7E;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_Y     = 8'h59;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;

  // Supported M codes.
  localparam logic [13:0] MCODE_A = 14'd114;
  localparam logic [13:0] MCODE_B = 14'd119;

  // Command code limit and coordinate magnitude limit.
  localparam logic [13:0] CODE_MAX = 14'd9999;
  localparam logic [30:0] SAT_MAX  = 31'h7FFF_FFFF;

  // Width of the fraction digit counter; covers up to six fraction digits.
  localparam int FCNT_W = 3;

  // Powers of ten for the fraction digit weights.
  function automatic logic [19:0] pow10(input logic [FCNT_W-1:0] n);
    logic [19:0] r;
    case (n)
      3'd0:    r = 20'd1;
      3'd1:    r = 20'd10;
      3'd2:    r = 20'd100;
      3'd3:    r = 20'd1000;
      3'd4:    r = 20'd10000;
      3'd5:    r = 20'd100000;
      3'd6:    r = 20'd1000000;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

endpackage

>>> src/gcode_line_parser_unit.sv
// ---------------------------------------------------------------------------
// gcode_line_parser_unit
// Streaming parser for plotter command lines, one character per item.
// ---------------------------------------------------------------------------
// The block takes one item per clock: either a character of a command line
// (in_tuser low) or an end-of-line marker (in_tuser high). Each character
// updates the parse state in the cycle it is accepted; each end-of-line item
// loads one result into the output register, which shows it on the next
// cycle, and clears the parser for the next line. Throughput is one item
// per cycle. Input is held off only while the output register holds a
// result the downstream side has not taken. X and Y are returned in signed
// fixed point with FRAC_DIGITS fraction digits (0 to 6).
module gcode_line_parser_unit #(
  parameter int FRAC_DIGITS = 3
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] ch
  input  logic        in_tuser,   // [0] kind
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] ok, [4:1] error_code, [7:5] command_letter, [22:8] command_number,
  // [23] has_x, [24] has_y, [56:25] x_milli, [88:57] y_milli, [89] pen_down,
  // [95:90] zero
  output logic [95:0] out_tdata
);

  localparam int FW = glp_pkg::FCNT_W;

  typedef enum logic [2:0] {
    PH_IDLE, PH_CODE_FIRST, PH_CODE, PH_COORDS, PH_VAL_FIRST, PH_VALUE, PH_DONE
  } phase_t;

  phase_t          phase_r, phase_nxt;
  logic [2:0]      letter_r, letter_nxt;
  logic [13:0]     number_r, number_nxt;
  logic            num_present_r, num_present_nxt;
  logic [31:0]     x_r, x_nxt, y_r, y_nxt;
  logic            x_flag_r, x_flag_nxt, y_flag_r, y_flag_nxt;
  logic [30:0]     acc_r, acc_nxt;
  logic [FW-1:0]   fcnt_r, fcnt_nxt;
  logic [1:0]      dot_r, dot_nxt;
  logic            neg_r, neg_nxt;
  logic            tgt_y_r, tgt_y_nxt;
  logic [3:0]      err_r, err_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic [95:0]     out_data_r, out_data_nxt;

  logic            in_acc;
  logic [7:0]      c_up;
  logic [3:0]      digit;
  logic            is_digit, is_blank_lead, is_space_tab;
  logic [31:0]     commit_v;
  logic [17:0]     code_sum;
  logic [35:0]     int_sum, frac_sum;
  logic [FW-1:0]   fcnt_inc;
  logic            do_value, do_coord;

  // Result side.
  logic [3:0]      fin_err;
  logic            fin_xf, fin_yf, fin_pen;
  logic [31:0]     fin_x, fin_y;
  logic [14:0]     fin_code;
  logic            code_is_0, code_is_1;

  // Handshake: the output register is the only place a result waits.
  assign in_acc     = in_tvalid && in_tready;
  assign in_tready  = !out_valid_r || out_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Character classification after folding to upper case.
  always_comb begin
    c_up = in_tdata;
    if (in_tdata >= glp_pkg::CH_LC_A && in_tdata <= glp_pkg::CH_LC_Z) begin
      c_up = in_tdata - 8'd32;
    end
    digit         = c_up[3:0];
    is_digit      = (c_up >= glp_pkg::CH_ZERO) && (c_up <= glp_pkg::CH_NINE);
    is_blank_lead = (c_up == glp_pkg::CH_SPACE) ||
                    ((c_up >= glp_pkg::CH_TAB) && (c_up <= glp_pkg::CH_CR));
    is_space_tab  = (c_up == glp_pkg::CH_SPACE) || (c_up == glp_pkg::CH_TAB);
  end

  // Arithmetic for one digit: code times ten, integer and fraction weights.
  always_comb begin
    commit_v = neg_r ? (32'd0 - {1'b0, acc_r}) : {1'b0, acc_r};
    code_sum = {1'b0, number_r, 3'b000} + {3'b000, number_r, 1'b0} + {14'd0, digit};
    int_sum  = {2'b00, acc_r, 3'b000} + {4'b0000, acc_r, 1'b0}
             + {12'd0, 24'(digit * glp_pkg::pow10(FW'(FRAC_DIGITS)))};
    fcnt_inc = fcnt_r + FW'(1);
    frac_sum = {5'd0, acc_r}
             + {12'd0, 24'(digit * glp_pkg::pow10(FW'(FRAC_DIGITS) - fcnt_inc))};
  end

  // Parse state update for one accepted item.
  always_comb begin
    phase_nxt       = phase_r;
    letter_nxt      = letter_r;
    number_nxt      = number_r;
    num_present_nxt = num_present_r;
    x_nxt           = x_r;
    y_nxt           = y_r;
    x_flag_nxt      = x_flag_r;
    y_flag_nxt      = y_flag_r;
    acc_nxt         = acc_r;
    fcnt_nxt        = fcnt_r;
    dot_nxt         = dot_r;
    neg_nxt         = neg_r;
    tgt_y_nxt       = tgt_y_r;
    err_nxt         = err_r;
    do_value        = 1'b0;
    do_coord        = 1'b0;
    if (in_acc) begin
      if (in_tuser == glp_pkg::KIND_EOL) begin
        // End of line clears the whole parse state.
        phase_nxt       = PH_IDLE;
        letter_nxt      = glp_pkg::LET_NONE;
        number_nxt      = '0;
        num_present_nxt = 1'b0;
        x_nxt           = '0;
        y_nxt           = '0;
        x_flag_nxt      = 1'b0;
        y_flag_nxt      = 1'b0;
        acc_nxt         = '0;
        fcnt_nxt        = '0;
        dot_nxt         = '0;
        neg_nxt         = 1'b0;
        tgt_y_nxt       = 1'b0;
        err_nxt         = glp_pkg::ERR_NONE;
      end else begin
        case (phase_r)
          PH_IDLE: begin
            if (!is_blank_lead) begin
              case (c_up)
                glp_pkg::CH_G: begin
                  letter_nxt = glp_pkg::LET_G;
                  phase_nxt  = PH_CODE_FIRST;
                end
                glp_pkg::CH_D: begin
                  letter_nxt = glp_pkg::LET_D;
                  phase_nxt  = PH_COORDS;
                end
                glp_pkg::CH_P: begin
                  letter_nxt = glp_pkg::LET_P;
                  phase_nxt  = PH_CODE_FIRST;
                end
                glp_pkg::CH_H: begin
                  letter_nxt = glp_pkg::LET_H;
                  phase_nxt  = PH_COORDS;
                end
                glp_pkg::CH_M: begin
                  letter_nxt = glp_pkg::LET_M;
                  phase_nxt  = PH_CODE_FIRST;
                end
                glp_pkg::CH_BANG: begin
                  letter_nxt = glp_pkg::LET_BANG;
                  phase_nxt  = PH_COORDS;
                end
                glp_pkg::CH_TILDE: begin
                  letter_nxt = glp_pkg::LET_TILDE;
                  phase_nxt  = PH_COORDS;
                end
                default: begin
                  err_nxt   = glp_pkg::ERR_BAD_TYPE;
                  phase_nxt = PH_DONE;
                end
              endcase
            end
          end
          PH_CODE_FIRST, PH_CODE: begin
            if (is_digit) begin
              number_nxt      = (code_sum > {4'd0, glp_pkg::CODE_MAX}) ?
                                glp_pkg::CODE_MAX : code_sum[13:0];
              num_present_nxt = 1'b1;
              phase_nxt       = PH_CODE;
            end else if (phase_r == PH_CODE_FIRST) begin
              err_nxt   = glp_pkg::ERR_NO_CODE;
              phase_nxt = PH_DONE;
            end else begin
              do_coord = 1'b1;
            end
          end
          PH_COORDS: begin
            do_coord = 1'b1;
          end
          PH_VAL_FIRST: begin
            if (c_up == glp_pkg::CH_MINUS) begin
              neg_nxt   = 1'b1;
              phase_nxt = PH_VALUE;
            end else if (is_digit || c_up == glp_pkg::CH_DOT) begin
              phase_nxt = PH_VALUE;
              do_value  = 1'b1;
            end else begin
              err_nxt   = glp_pkg::ERR_BAD_COORD;
              phase_nxt = PH_DONE;
            end
          end
          PH_VALUE: begin
            do_value = 1'b1;
          end
          default: begin
          end
        endcase

        // Value characters: dots, digits, or a character that ends the value.
        if (do_value) begin
          if (c_up == glp_pkg::CH_DOT) begin
            if (dot_r < 2'd2) begin
              dot_nxt = dot_r + 2'd1;
            end
          end else if (is_digit) begin
            if (dot_r == 2'd0) begin
              acc_nxt = (int_sum > {5'd0, glp_pkg::SAT_MAX}) ?
                        glp_pkg::SAT_MAX : int_sum[30:0];
            end else if (dot_r == 2'd1 && fcnt_r < FW'(FRAC_DIGITS)) begin
              fcnt_nxt = fcnt_inc;
              acc_nxt  = (frac_sum > {5'd0, glp_pkg::SAT_MAX}) ?
                         glp_pkg::SAT_MAX : frac_sum[30:0];
            end
          end else begin
            if (tgt_y_r) begin
              y_nxt      = commit_v;
              y_flag_nxt = 1'b1;
            end else begin
              x_nxt      = commit_v;
              x_flag_nxt = 1'b1;
            end
            do_coord = 1'b1;
          end
        end

        // Coordinate section: start a value, skip blanks, or stop parsing.
        if (do_coord) begin
          if (c_up == glp_pkg::CH_X || c_up == glp_pkg::CH_Y) begin
            tgt_y_nxt = (c_up == glp_pkg::CH_Y);
            acc_nxt   = '0;
            fcnt_nxt  = '0;
            dot_nxt   = '0;
            neg_nxt   = 1'b0;
            phase_nxt = PH_VAL_FIRST;
          end else if (is_space_tab) begin
            phase_nxt = PH_COORDS;
          end else begin
            phase_nxt = PH_DONE;
          end
        end
      end
    end
  end

  // End-of-line result: close an open value, derive pen state, validate.
  always_comb begin
    fin_err   = err_r;
    fin_x     = x_r;
    fin_y     = y_r;
    fin_xf    = x_flag_r;
    fin_yf    = y_flag_r;
    fin_pen   = 1'b0;
    fin_code  = num_present_r ? {1'b0, number_r} : '1;
    code_is_0 = num_present_r && (number_r == 14'd0);
    code_is_1 = num_present_r && (number_r == 14'd1);
    if (err_r == glp_pkg::ERR_NONE) begin
      case (phase_r)
        PH_IDLE:       fin_err = glp_pkg::ERR_EMPTY;
        PH_CODE_FIRST: fin_err = glp_pkg::ERR_NO_CODE;
        PH_VAL_FIRST:  fin_err = glp_pkg::ERR_BAD_COORD;
        PH_VALUE: begin
          if (tgt_y_r) begin
            fin_y  = commit_v;
            fin_yf = 1'b1;
          end else begin
            fin_x  = commit_v;
            fin_xf = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
    if (fin_err == glp_pkg::ERR_NONE) begin
      fin_pen = (((letter_r == glp_pkg::LET_G) || (letter_r == glp_pkg::LET_P)) &&
                 code_is_1) || (letter_r == glp_pkg::LET_D);
      if (letter_r == glp_pkg::LET_G && (code_is_0 || code_is_1)) begin
        if (!fin_xf && !fin_yf) begin
          fin_err = glp_pkg::ERR_MOVE_NO_XY;
        end
      end else if (letter_r == glp_pkg::LET_D) begin
        if (!fin_xf || !fin_yf) begin
          fin_err = glp_pkg::ERR_DOT_NO_XY;
        end
      end else if (letter_r == glp_pkg::LET_P && !code_is_0 && !code_is_1) begin
        fin_err = glp_pkg::ERR_PEN_CODE;
      end else if (letter_r == glp_pkg::LET_M &&
                   !(num_present_r && (number_r == glp_pkg::MCODE_A ||
                                       number_r == glp_pkg::MCODE_B))) begin
        fin_err = glp_pkg::ERR_BAD_M;
      end
    end
    out_data_nxt = {6'd0, fin_pen,
                    fin_yf ? fin_y : 32'd0,
                    fin_xf ? fin_x : 32'd0,
                    fin_yf, fin_xf, fin_code, letter_r, fin_err,
                    (fin_err == glp_pkg::ERR_NONE)};
  end

  // Output register valid: loads on end of line, drains when taken.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc && in_tuser == glp_pkg::KIND_EOL) begin
      out_valid_nxt = 1'b1;
    end
  end

  // State and output registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r       <= PH_IDLE;
      letter_r      <= glp_pkg::LET_NONE;
      number_r      <= '0;
      num_present_r <= 1'b0;
      x_r           <= '0;
      y_r           <= '0;
      x_flag_r      <= 1'b0;
      y_flag_r      <= 1'b0;
      acc_r         <= '0;
      fcnt_r        <= '0;
      dot_r         <= '0;
      neg_r         <= 1'b0;
      tgt_y_r       <= 1'b0;
      err_r         <= glp_pkg::ERR_NONE;
      out_valid_r   <= 1'b0;
    end else begin
      phase_r       <= phase_nxt;
      letter_r      <= letter_nxt;
      number_r      <= number_nxt;
      num_present_r <= num_present_nxt;
      x_r           <= x_nxt;
      y_r           <= y_nxt;
      x_flag_r      <= x_flag_nxt;
      y_flag_r      <= y_flag_nxt;
      acc_r         <= acc_nxt;
      fcnt_r        <= fcnt_nxt;
      dot_r         <= dot_nxt;
      neg_r         <= neg_nxt;
      tgt_y_r       <= tgt_y_nxt;
      err_r         <= err_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    if (in_acc && in_tuser == glp_pkg::KIND_EOL) begin
      out_data_r <= out_data_nxt;
    end
  end

  // Checks on the parser's own logic.
`include "gcode_line_parser_unit_defines.svh"

  `GLP_ASSERT_NEXT(a_eol_gives_result, in_acc && in_tuser == glp_pkg::KIND_EOL, out_tvalid, "end of line did not produce a result")
  `GLP_ASSERT_NEXT(a_eol_clears_state, in_acc && in_tuser == glp_pkg::KIND_EOL, phase_r == PH_IDLE && err_r == glp_pkg::ERR_NONE && !x_flag_r && !y_flag_r, "parser not cleared after end of line")
  `GLP_ASSERT_NOW(a_ok_matches_err, out_tvalid, out_tdata[0] == (out_tdata[4:1] == glp_pkg::ERR_NONE), "ok flag disagrees with error code")
  `GLP_ASSERT_NOW(a_pen_letter, out_tvalid && out_tdata[89], out_tdata[7:5] == glp_pkg::LET_G || out_tdata[7:5] == glp_pkg::LET_P || out_tdata[7:5] == glp_pkg::LET_D, "pen down on a command that cannot lower it")

endmodule

>>> bench/gcode_line_parser_unit_tb.sv
// ---------------------------------------------------------------------------
// gcode_line_parser_unit_tb
// Self-checking bench for the streaming plotter command line parser.
// ---------------------------------------------------------------------------
// Characters and end-of-line markers are sent over the input stream. A
// behavioral parser in the bench follows every accepted item and queues the
// result expected for each end-of-line item. A checker compares every result
// taken from the output stream with the oldest queued result, field by field.
// Directed lines cover each command, each error and the number-format corner
// cases. Random lines follow: mostly well-formed commands with random codes
// and coordinates, plus noise bytes and broken lines. Both stream sides idle
// at random, and there are phases at full rate, under a long output stall,
// and with the sender held until all results have drained.
// ---------------------------------------------------------------------------
module gcode_line_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_DIGITS = 3;
  localparam longint unsigned MAG_LIMIT = 64'h7FFF_FFFF;
  localparam int CODE_LIMIT = 9999;
  localparam int CYCLE_LIMIT = 200000;
  localparam int DRAIN_LIMIT = 5000;
  localparam int IDLE_PCT = 19;

  // Parse phases of the behavioral parser.
  typedef enum logic [2:0] {
    PH_IDLE, PH_CODE_FIRST, PH_CODE, PH_COORDS, PH_VAL_FIRST, PH_VALUE, PH_DONE
  } parse_phase_t;

  typedef struct {
    logic        ok;
    logic [3:0]  error_code;
    logic [2:0]  letter;
    logic [14:0] number;
    logic        has_x;
    logic        has_y;
    logic [31:0] x_milli;
    logic [31:0] y_milli;
    logic        pen_down;
  } line_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'd0;    // [7:0] ch
  logic        in_tuser = 1'b0;    // [0] kind
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  // [0] ok, [4:1] error_code, [7:5] command_letter, [22:8] command_number,
  // [23] has_x, [24] has_y, [56:25] x_milli, [88:57] y_milli, [89] pen_down
  logic [95:0] out_tdata;

  // Bench bookkeeping.
  line_result_t pending_lines[$];
  int          mismatch_count = 0;
  int          items_sent = 0;
  int          cycle_count = 0;
  int          tx_idle_pct = IDLE_PCT;
  int          rx_idle_pct = IDLE_PCT;
  int          rx_stall_len = 0;
  bit          rx_hold = 1'b0;
  event        rx_stall_go;
  int          noise_permille = 0;

  // Behavioral parser state.
  parse_phase_t p_phase = PH_IDLE;
  logic [2:0]   p_letter = glp_pkg::LET_NONE;
  int           p_code = 0;
  bit           p_code_seen = 1'b0;
  logic [31:0]  p_x = '0;
  logic [31:0]  p_y = '0;
  bit           p_has_x = 1'b0;
  bit           p_has_y = 1'b0;
  logic [31:0]  p_acc = '0;
  int           p_frac_n = 0;
  int           p_dots = 0;
  bit           p_neg = 1'b0;
  bit           p_to_y = 1'b0;
  logic [3:0]   p_err = glp_pkg::ERR_NONE;

  gcode_line_parser_unit #(
    .FRAC_DIGITS(FRAC_DIGITS)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Run limit, counted in clock cycles.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // Behavioral parser
  // ---------------------------------------------------------------------

  function automatic bit is_digit(input logic [7:0] c);
    return c >= glp_pkg::CH_ZERO && c <= glp_pkg::CH_NINE;
  endfunction

  function automatic void clear_parse();
    p_phase = PH_IDLE;
    p_letter = glp_pkg::LET_NONE;
    p_code = 0;
    p_code_seen = 1'b0;
    p_x = '0;
    p_y = '0;
    p_has_x = 1'b0;
    p_has_y = 1'b0;
    p_acc = '0;
    p_frac_n = 0;
    p_dots = 0;
    p_neg = 1'b0;
    p_to_y = 1'b0;
    p_err = glp_pkg::ERR_NONE;
  endfunction

  // Moves the accumulated magnitude, with its sign, into X or Y.
  function automatic void store_value();
    logic [31:0] v;
    v = p_neg ? (32'd0 - p_acc) : p_acc;
    if (p_to_y) begin
      p_y = v;
      p_has_y = 1'b1;
    end else begin
      p_x = v;
      p_has_x = 1'b1;
    end
  endfunction

  // Coordinate section: an axis letter opens a value, blanks are skipped,
  // anything else stops the parse.
  function automatic void scan_coord(input logic [7:0] c);
    if (c == glp_pkg::CH_X || c == glp_pkg::CH_Y) begin
      p_to_y = (c == glp_pkg::CH_Y);
      p_acc = '0;
      p_frac_n = 0;
      p_dots = 0;
      p_neg = 1'b0;
      p_phase = PH_VAL_FIRST;
    end else if (c != glp_pkg::CH_SPACE && c != glp_pkg::CH_TAB) begin
      p_phase = PH_DONE;
    end
  endfunction

  // Inside a value: digits accumulate in fixed point, a second dot freezes
  // the value, any other character commits it.
  function automatic void scan_value(input logic [7:0] c);
    longint unsigned a;
    longint unsigned w;
    if (c == glp_pkg::CH_DOT) begin
      if (p_dots < 2) p_dots++;
    end else if (is_digit(c)) begin
      a = 64'(p_acc);
      if (p_dots == 0) begin
        w = 1;
        repeat (FRAC_DIGITS) w = w * 10;
        a = a * 10 + longint'(c - glp_pkg::CH_ZERO) * w;
      end else if (p_dots == 1 && p_frac_n < FRAC_DIGITS) begin
        p_frac_n++;
        w = 1;
        repeat (FRAC_DIGITS - p_frac_n) w = w * 10;
        a = a + longint'(c - glp_pkg::CH_ZERO) * w;
      end
      p_acc = (a > MAG_LIMIT) ? MAG_LIMIT[31:0] : a[31:0];
    end else begin
      store_value();
      p_phase = PH_COORDS;
      scan_coord(c);
    end
  endfunction

  function automatic void parse_char(input logic [7:0] raw);
    logic [7:0] c;
    c = raw;
    if (c >= glp_pkg::CH_LC_A && c <= glp_pkg::CH_LC_Z) c = c - 8'd32;
    case (p_phase)
      PH_IDLE: begin
        if (!(c == glp_pkg::CH_SPACE || (c >= glp_pkg::CH_TAB && c <= glp_pkg::CH_CR))) begin
          p_phase = PH_COORDS;
          case (c)
            glp_pkg::CH_G: begin
              p_letter = glp_pkg::LET_G;
              p_phase = PH_CODE_FIRST;
            end
            glp_pkg::CH_D: p_letter = glp_pkg::LET_D;
            glp_pkg::CH_P: begin
              p_letter = glp_pkg::LET_P;
              p_phase = PH_CODE_FIRST;
            end
            glp_pkg::CH_H: p_letter = glp_pkg::LET_H;
            glp_pkg::CH_M: begin
              p_letter = glp_pkg::LET_M;
              p_phase = PH_CODE_FIRST;
            end
            glp_pkg::CH_BANG: p_letter = glp_pkg::LET_BANG;
            glp_pkg::CH_TILDE: p_letter = glp_pkg::LET_TILDE;
            default: begin
              p_err = glp_pkg::ERR_BAD_TYPE;
              p_phase = PH_DONE;
            end
          endcase
        end
      end
      PH_CODE_FIRST, PH_CODE: begin
        if (is_digit(c)) begin
          p_code = p_code * 10 + int'(c - glp_pkg::CH_ZERO);
          if (p_code > CODE_LIMIT) p_code = CODE_LIMIT;
          p_code_seen = 1'b1;
          p_phase = PH_CODE;
        end else if (p_phase == PH_CODE_FIRST) begin
          p_err = glp_pkg::ERR_NO_CODE;
          p_phase = PH_DONE;
        end else begin
          p_phase = PH_COORDS;
          scan_coord(c);
        end
      end
      PH_COORDS: scan_coord(c);
      PH_VAL_FIRST: begin
        if (c == glp_pkg::CH_MINUS) begin
          p_neg = 1'b1;
          p_phase = PH_VALUE;
        end else if (is_digit(c) || c == glp_pkg::CH_DOT) begin
          p_phase = PH_VALUE;
          scan_value(c);
        end else begin
          p_err = glp_pkg::ERR_BAD_COORD;
          p_phase = PH_DONE;
        end
      end
      PH_VALUE: scan_value(c);
      default: ;
    endcase
  endfunction

  // End of line: validate, build the result and clear for the next line.
  function automatic line_result_t close_line();
    line_result_t r;
    logic [3:0]   e;
    bit           pen;
    int           code;
    code = p_code_seen ? p_code : -1;
    e = p_err;
    pen = 1'b0;
    if (e == glp_pkg::ERR_NONE) begin
      if (p_phase == PH_IDLE) e = glp_pkg::ERR_EMPTY;
      else if (p_phase == PH_CODE_FIRST) e = glp_pkg::ERR_NO_CODE;
      else if (p_phase == PH_VAL_FIRST) e = glp_pkg::ERR_BAD_COORD;
      else if (p_phase == PH_VALUE) store_value();
    end
    if (e == glp_pkg::ERR_NONE) begin
      pen = ((p_letter == glp_pkg::LET_G || p_letter == glp_pkg::LET_P) && code == 1) ||
            p_letter == glp_pkg::LET_D;
      if (p_letter == glp_pkg::LET_G && (code == 0 || code == 1)) begin
        if (!p_has_x && !p_has_y) e = glp_pkg::ERR_MOVE_NO_XY;
      end else if (p_letter == glp_pkg::LET_D) begin
        if (!p_has_x || !p_has_y) e = glp_pkg::ERR_DOT_NO_XY;
      end else if (p_letter == glp_pkg::LET_P && code != 0 && code != 1) begin
        e = glp_pkg::ERR_PEN_CODE;
      end else if (p_letter == glp_pkg::LET_M && code != int'(glp_pkg::MCODE_A) &&
                   code != int'(glp_pkg::MCODE_B)) begin
        e = glp_pkg::ERR_BAD_M;
      end
    end
    r.ok = (e == glp_pkg::ERR_NONE);
    r.error_code = e;
    r.letter = p_letter;
    r.number = code[14:0];
    r.has_x = p_has_x;
    r.has_y = p_has_y;
    r.x_milli = p_has_x ? p_x : 32'd0;
    r.y_milli = p_has_y ? p_y : 32'd0;
    r.pen_down = pen;
    clear_parse();
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Result side: checks each accepted item and drives tready
  // ---------------------------------------------------------------------

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : result_side
    line_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_lines.size() == 0) begin
        $error("result item arrived with no result expected");
        mismatch_count++;
      end else begin
        want = pending_lines.pop_front();
        check_field("ok", 32'(want.ok), 32'(out_tdata[0]));
        check_field("error_code", 32'(want.error_code), 32'(out_tdata[4:1]));
        check_field("command_letter", 32'(want.letter), 32'(out_tdata[7:5]));
        check_field("command_number", 32'(want.number), 32'(out_tdata[22:8]));
        check_field("has_x", 32'(want.has_x), 32'(out_tdata[23]));
        check_field("has_y", 32'(want.has_y), 32'(out_tdata[24]));
        check_field("x_milli", want.x_milli, out_tdata[56:25]);
        check_field("y_milli", want.y_milli, out_tdata[88:57]);
        check_field("pen_down", 32'(want.pen_down), 32'(out_tdata[89]));
      end
    end
    // A requested stall holds tready low; otherwise idle at random.
    if (rx_hold) begin
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end
  end

  // Long receiver stall, counted in clock cycles, started on request.
  always begin : rx_stall
    @(rx_stall_go);
    rx_hold <= 1'b1;
    repeat (rx_stall_len) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // ---------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------

  // Offers one item, with random idle cycles first, and waits for it to be
  // taken. The parser model follows the item once it is accepted.
  task automatic send_item(input logic kind, input logic [7:0] ch);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= kind;
    in_tdata <= ch;
    do @(posedge clk); while (!in_tready);
    items_sent++;
    if (kind == glp_pkg::KIND_EOL) pending_lines.push_back(close_line());
    else parse_char(ch);
  endtask

  // One character, sometimes preceded by a random noise byte.
  task automatic send_char(input logic [7:0] c);
    if ($urandom_range(0, 999) < noise_permille)
      send_item(glp_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
    send_item(glp_pkg::KIND_CHAR, c);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_char(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_item(glp_pkg::KIND_EOL, 8'd0);
  endtask

  task automatic send_digits(input int n);
    repeat (n) send_char(8'(glp_pkg::CH_ZERO + $urandom_range(0, 9)));
  endtask

  // Drops tvalid and waits, within a bound, until every result has come.
  task automatic drain_results();
    int waited;
    waited = 0;
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_lines.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
  endtask

  // A random command line. Most lines are well formed with random content;
  // some carry noise bytes, some are pure noise.
  task automatic send_random_line();
    logic [7:0] c;
    int         n;
    noise_permille = ($urandom_range(0, 99) < 20) ? 60 : 0;
    if ($urandom_range(0, 99) < 6) begin
      repeat ($urandom_range(0, 6))
        send_item(glp_pkg::KIND_CHAR, 8'($urandom_range(0, 255)));
      send_item(glp_pkg::KIND_EOL, 8'($urandom_range(0, 255)));
      return;
    end
    // Leading blanks.
    if ($urandom_range(0, 3) == 0)
      repeat ($urandom_range(1, 3))
        send_char($urandom_range(0, 1) ? glp_pkg::CH_SPACE
                  : 8'($urandom_range(glp_pkg::CH_TAB, glp_pkg::CH_CR)));
    // Command letter, sometimes in lower case.
    case ($urandom_range(0, 11))
      0, 1, 2, 3: c = glp_pkg::CH_G;
      4:          c = glp_pkg::CH_D;
      5, 6:       c = glp_pkg::CH_P;
      7:          c = glp_pkg::CH_H;
      8, 9:       c = glp_pkg::CH_M;
      10:         c = glp_pkg::CH_BANG;
      default:    c = glp_pkg::CH_TILDE;
    endcase
    if (c != glp_pkg::CH_BANG && c != glp_pkg::CH_TILDE && $urandom_range(0, 1))
      c = c | 8'h20;
    send_char(c);
    // Numeric code, biased toward the values that matter.
    if (c == glp_pkg::CH_G || c == glp_pkg::CH_P || c == glp_pkg::CH_M ||
        c == (glp_pkg::CH_G | 8'h20) || c == (glp_pkg::CH_P | 8'h20) ||
        c == (glp_pkg::CH_M | 8'h20) || $urandom_range(0, 9) == 0) begin
      case ($urandom_range(0, 7))
        0:       n = -1;
        1, 2:    n = 0;
        3, 4:    n = 1;
        5:       n = $urandom_range(0, 1) ? int'(glp_pkg::MCODE_A) : int'(glp_pkg::MCODE_B);
        6:       n = $urandom_range(0, 99);
        default: n = $urandom_range(0, 20000000);
      endcase
      if (n >= 0) send_text($sformatf("%0d", n));
    end
    // Coordinates.
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 1)) send_char(glp_pkg::CH_SPACE);
      c = $urandom_range(0, 1) ? glp_pkg::CH_X : glp_pkg::CH_Y;
      if ($urandom_range(0, 3) == 0) c = c | 8'h20;
      send_char(c);
      if ($urandom_range(0, 3) == 0) send_char(glp_pkg::CH_MINUS);
      send_digits(($urandom_range(0, 15) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 4));
      if ($urandom_range(0, 2) != 0) begin
        send_char(glp_pkg::CH_DOT);
        send_digits($urandom_range(0, 5));
        if ($urandom_range(0, 9) == 0) begin
          send_char(glp_pkg::CH_DOT);
          send_digits($urandom_range(0, 2));
        end
      end
    end
    // Trailing blanks.
    if ($urandom_range(0, 4) == 0)
      repeat ($urandom_range(1, 2))
        send_char($urandom_range(0, 1) ? glp_pkg::CH_SPACE : glp_pkg::CH_CR);
    send_item(glp_pkg::KIND_EOL, 8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Each command, each error and the number-format corner cases.
  task automatic test_directed();
    noise_permille = 0;
    send_line("");
    send_line(" \x09\x0A\x0B\x0C\x0D ");
    send_line(" \x09\x0D g1 x12.5 y-0.125  ");
    send_line("g0x.5y-");
    send_line("D X-1 Y2");
    send_line("D X3");
    send_line("P0");
    send_line("P1");
    send_line("P7");
    send_line("P");
    send_line("H");
    send_line("!");
    send_line("~ X1");
    send_line("M114");
    send_line("m119");
    send_line("M5");
    send_line("Q1");
    send_line("\xFF\x80");
    send_line("G X1");
    send_line("G1 XZ");
    send_line("G1 Y");
    send_line("G1");
    send_line("G0123456 X1");
    send_line("G1 X99999999999 Y-3000000.5");
    send_line("G1 X1.23456 Y1.2.3");
    send_line("G1 X1-5 Y2");
    send_line("G1 X1 X2.5");
    send_line("G1 X1 ;Y2");
  endtask

  task automatic test_random_lines(input int n_items);
    int start;
    start = items_sent;
    while (items_sent - start < n_items) send_random_line();
  endtask

  // No idling on either side.
  task automatic test_full_rate();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    test_random_lines(250);
    tx_idle_pct = IDLE_PCT;
    rx_idle_pct = IDLE_PCT;
  endtask

  // The receiver stalls for a long stretch while lines keep coming, so the
  // result register fills and the input is held off.
  task automatic test_output_stall();
    rx_stall_len = 400;
    -> rx_stall_go;
    noise_permille = 0;
    repeat (4) begin
      send_line("H");
      send_line("G1X1Y-1");
      send_line("M114");
    end
  endtask

  // The sender pauses until every result has come, then resumes.
  task automatic test_drain_pause();
    test_random_lines(60);
    drain_results();
    test_random_lines(60);
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_lines(700);
    test_output_stall();
    test_full_rate();
    test_drain_pause();
    test_random_lines(460);
    drain_results();
    repeat (4) @(posedge clk);
    if (pending_lines.size() != 0) begin
      $error("%0d expected results never arrived", pending_lines.size());
    end
    if (mismatch_count == 0 && pending_lines.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
